/* hw/rtl/lbpc_pkg.sv */
// Package for the LED blink pattern controller: mode codes, register
// indexes, toggle periods and reset defaults. No dependencies.
package lbpc_pkg;

  localparam int NumLedsDefault  = 3;
  localparam int TimeBitsDefault = 32;
  localparam int ModeRegs        = 3;
  localparam int NumOutLeds      = 3;

  localparam int ModeW  = 3;
  localparam int CfgIdW = 3;
  localparam int CfgDW  = 16;
  localparam int TickW  = 16;
  localparam int CountW = 8;
  localparam int ElapW  = 10;

  localparam logic [ModeW-1:0] MODE_OFF     = 3'd0;
  localparam logic [ModeW-1:0] MODE_ON      = 3'd1;
  localparam logic [ModeW-1:0] MODE_FAST    = 3'd2;
  localparam logic [ModeW-1:0] MODE_SLOW    = 3'd3;
  localparam logic [ModeW-1:0] MODE_PROFILE = 3'd4;

  localparam logic [CfgIdW-1:0] REG_MODE_POWER  = 3'd0;
  localparam logic [CfgIdW-1:0] REG_MODE_GPS    = 3'd1;
  localparam logic [CfgIdW-1:0] REG_MODE_TX     = 3'd2;
  localparam logic [CfgIdW-1:0] REG_CYCLE       = 3'd3;
  localparam logic [CfgIdW-1:0] REG_ON_TICKS    = 3'd4;
  localparam logic [CfgIdW-1:0] REG_OFF_TICKS   = 3'd5;
  localparam logic [CfgIdW-1:0] REG_PULSE_COUNT = 3'd6;

  localparam logic [TickW-1:0] FAST_TICKS = 16'd150;
  localparam logic [TickW-1:0] SLOW_TICKS = 16'd500;

  localparam logic [TickW-1:0]  CYCLE_RST       = 16'd5000;
  localparam logic [TickW-1:0]  ON_TICKS_RST    = 16'd2000;
  localparam logic [TickW-1:0]  OFF_TICKS_RST   = 16'd500;
  localparam logic [CountW-1:0] PULSE_COUNT_RST = 8'd2;
  localparam logic [CountW-1:0] COUNT_MAX       = 8'hFF;

endpackage

/* hw/rtl/led_blink_pattern_controller_core.sv */
// LED blink pattern controller top level: tick counter, per-LED mode logic
// and blink profile sequencing. Depends on lbpc_pkg.
// Structure: input register, then update logic into the result register.
// Throughput: one item per cycle; an output stall holds the input.
// Reset: asynchronous, active low; modes off, profile registers at their
// defaults, time counter, stamps and LED state cleared.
module led_blink_pattern_controller_core #(
  parameter int NUM_LEDS  = lbpc_pkg::NumLedsDefault,
  parameter int TIME_BITS = lbpc_pkg::TimeBitsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lbpc_pkg::ElapW-1:0]   elapsed_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         power_led_o,
  output logic                         gps_led_o,
  output logic                         transmitter_led_o,
  output logic                         cycle_restarted_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lbpc_pkg::CfgIdW-1:0]  cfg_index_i,
  input  logic [lbpc_pkg::CfgDW-1:0]   cfg_data_i
);

  logic [lbpc_pkg::ModeW-1:0]  mode_q [lbpc_pkg::ModeRegs];
  logic [lbpc_pkg::TickW-1:0]  cycle_period_q, on_ticks_q, off_ticks_q;
  logic [lbpc_pkg::CountW-1:0] pulse_count_q;

  logic                       s1_valid_q;
  logic [lbpc_pkg::ElapW-1:0] elapsed_q;
  logic                       advance, fire, in_accept;

  logic [TIME_BITS-1:0] time_q, time_d, cycle_start_q, cycle_start_d;
  logic                 restart;

  logic [lbpc_pkg::ModeW-1:0]  led_mode [NUM_LEDS];
  logic                        lvl_q    [NUM_LEDS];
  logic                        lvl_d    [NUM_LEDS];
  logic [TIME_BITS-1:0]        tstamp_q [NUM_LEDS];
  logic [TIME_BITS-1:0]        tstamp_d [NUM_LEDS];
  logic [TIME_BITS-1:0]        pstamp_q [NUM_LEDS];
  logic [TIME_BITS-1:0]        pstamp_d [NUM_LEDS];
  logic [lbpc_pkg::CountW-1:0] done_q   [NUM_LEDS];
  logic [lbpc_pkg::CountW-1:0] done_d   [NUM_LEDS];
  logic                        lit_q    [NUM_LEDS];
  logic                        lit_d    [NUM_LEDS];
  logic                        fin_q    [NUM_LEDS];
  logic                        fin_d    [NUM_LEDS];

  logic [lbpc_pkg::NumOutLeds-1:0] out_lvl, out_lvl_q;
  logic                            out_valid_q, out_restart_q;

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lbpc_pkg::ModeRegs; i++) begin
        mode_q[i] <= lbpc_pkg::MODE_OFF;
      end
      cycle_period_q <= lbpc_pkg::CYCLE_RST;
      on_ticks_q     <= lbpc_pkg::ON_TICKS_RST;
      off_ticks_q    <= lbpc_pkg::OFF_TICKS_RST;
      pulse_count_q  <= lbpc_pkg::PULSE_COUNT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        lbpc_pkg::REG_MODE_POWER:  mode_q[0] <= cfg_data_i[lbpc_pkg::ModeW-1:0];
        lbpc_pkg::REG_MODE_GPS:    mode_q[1] <= cfg_data_i[lbpc_pkg::ModeW-1:0];
        lbpc_pkg::REG_MODE_TX:     mode_q[2] <= cfg_data_i[lbpc_pkg::ModeW-1:0];
        lbpc_pkg::REG_CYCLE:       cycle_period_q <= cfg_data_i;
        lbpc_pkg::REG_ON_TICKS:    on_ticks_q <= cfg_data_i;
        lbpc_pkg::REG_OFF_TICKS:   off_ticks_q <= cfg_data_i;
        lbpc_pkg::REG_PULSE_COUNT: pulse_count_q <= cfg_data_i[lbpc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and input register
  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      elapsed_q <= elapsed_i;
    end
  end

  // LEDs without a mode register stay off
  for (genvar g = 0; g < NUM_LEDS; g++) begin : g_mode
    if (g < lbpc_pkg::ModeRegs) begin : g_reg
      assign led_mode[g] = mode_q[g];
    end else begin : g_off
      assign led_mode[g] = lbpc_pkg::MODE_OFF;
    end
  end

  // Update logic
  always_comb begin
    time_d        = time_q + TIME_BITS'(elapsed_q);
    restart       = (time_d - cycle_start_q) >= TIME_BITS'(cycle_period_q);
    cycle_start_d = restart ? time_d : cycle_start_q;
    for (int i = 0; i < NUM_LEDS; i++) begin
      lvl_d[i]    = lvl_q[i];
      tstamp_d[i] = tstamp_q[i];
      pstamp_d[i] = pstamp_q[i];
      done_d[i]   = done_q[i];
      lit_d[i]    = lit_q[i];
      fin_d[i]    = fin_q[i];
      if (restart && led_mode[i] == lbpc_pkg::MODE_PROFILE) begin
        done_d[i]   = '0;
        lit_d[i]    = 1'b0;
        fin_d[i]    = 1'b0;
        pstamp_d[i] = time_d;
        lvl_d[i]    = 1'b0;
      end
      case (led_mode[i])
        lbpc_pkg::MODE_OFF: begin
          lvl_d[i] = 1'b0;
        end
        lbpc_pkg::MODE_ON: begin
          lvl_d[i] = 1'b1;
        end
        lbpc_pkg::MODE_FAST, lbpc_pkg::MODE_SLOW: begin
          if ((time_d - tstamp_q[i]) >= TIME_BITS'((led_mode[i] == lbpc_pkg::MODE_SLOW) ?
              lbpc_pkg::SLOW_TICKS : lbpc_pkg::FAST_TICKS)) begin
            lvl_d[i]    = !lvl_q[i];
            tstamp_d[i] = time_d;
          end
        end
        lbpc_pkg::MODE_PROFILE: begin
          if (fin_d[i]) begin
            lvl_d[i] = 1'b0;
          end else if (lit_d[i]) begin
            if ((time_d - pstamp_d[i]) >= TIME_BITS'(on_ticks_q)) begin
              lvl_d[i]    = 1'b0;
              lit_d[i]    = 1'b0;
              pstamp_d[i] = time_d;
              if (done_d[i] != lbpc_pkg::COUNT_MAX) begin
                done_d[i] = done_d[i] + lbpc_pkg::CountW'(1);
              end
              if (done_d[i] >= pulse_count_q) begin
                fin_d[i] = 1'b1;
              end
            end
          end else if (done_d[i] < pulse_count_q &&
                       (time_d - pstamp_d[i]) >= TIME_BITS'(off_ticks_q)) begin
            lvl_d[i]    = 1'b1;
            lit_d[i]    = 1'b1;
            pstamp_d[i] = time_d;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q        <= '0;
      cycle_start_q <= '0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        lvl_q[i]    <= 1'b0;
        tstamp_q[i] <= '0;
        pstamp_q[i] <= '0;
        done_q[i]   <= '0;
        lit_q[i]    <= 1'b0;
        fin_q[i]    <= 1'b0;
      end
    end else if (fire) begin
      time_q        <= time_d;
      cycle_start_q <= cycle_start_d;
      for (int i = 0; i < NUM_LEDS; i++) begin
        lvl_q[i]    <= lvl_d[i];
        tstamp_q[i] <= tstamp_d[i];
        pstamp_q[i] <= pstamp_d[i];
        done_q[i]   <= done_d[i];
        lit_q[i]    <= lit_d[i];
        fin_q[i]    <= fin_d[i];
      end
    end
  end

  // Result register
  for (genvar g = 0; g < lbpc_pkg::NumOutLeds; g++) begin : g_out
    if (g < NUM_LEDS) begin : g_led
      assign out_lvl[g] = lvl_d[g];
    end else begin : g_none
      assign out_lvl[g] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_lvl_q     <= out_lvl;
      out_restart_q <= restart;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign power_led_o       = out_lvl_q[0];
  assign gps_led_o         = out_lvl_q[1];
  assign transmitter_led_o = out_lvl_q[2];
  assign cycle_restarted_o = out_restart_q;

  // Assertions
  a_restart_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && restart |=> cycle_start_q == time_q)
    else $error("cycle start not stamped on restart");

  a_time_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(time_q))
    else $error("time counter moved without a transfer");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free pipeline");

endmodule
